// ----- rtl/mted_pkg.sv -----
// Shared types and constants for the transfer-encoding detector.
package mted_pkg;

  localparam int LINE_BITS = 11;
  localparam logic [LINE_BITS-1:0] LINE_MAX_LEN = 11'd990;
  localparam logic [LINE_BITS-1:0] LINE_SAT = 11'd2047;

  localparam logic [7:0] BYTE_NUL = 8'h00;
  localparam logic [7:0] BYTE_TAB = 8'h09;
  localparam logic [7:0] BYTE_LF = 8'h0A;
  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;
  localparam logic [7:0] HIGH_BYTE = 8'h80;

  localparam logic [1:0] ENC_7BIT = 2'd0;
  localparam logic [1:0] ENC_8BIT = 2'd1;
  localparam logic [1:0] ENC_QP = 2'd2;
  localparam logic [1:0] ENC_BASE64 = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic last_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0] encoding_kind;
    logic binary_found;
  } out_word_t;

endpackage

// ----- rtl/mted_stats.sv -----
// Body statistics counters and encoding decision.
module mted_stats import mted_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      take,
  input  in_word_t  word,
  input  logic      force_seven_bit,
  output out_word_t result
);

  localparam int TEN_BITS = COUNT_BITS + 4;
  localparam logic [TEN_BITS-1:0] TEN = TEN_BITS'(10);

  logic [COUNT_BITS-1:0] total_count, total_count_next;
  logic [COUNT_BITS-1:0] special_count, special_count_next;
  // ten times special_count, kept so that the tenth test needs no divider
  logic [TEN_BITS-1:0]   ten_special, ten_special_next;
  logic [LINE_BITS-1:0]  line_length, line_length_next;
  logic                  long_line_seen, long_line_seen_next;
  logic                  nul_seen, nul_seen_next;

  logic                  is_special;
  logic [LINE_BITS:0]    line_sum;
  logic [LINE_BITS-1:0]  line_sat;

  assign is_special = (word.data_byte < CTRL_LIMIT || word.data_byte >= HIGH_BYTE) &&
                      word.data_byte != BYTE_TAB && word.data_byte != BYTE_CR &&
                      word.data_byte != BYTE_LF;
  assign line_sum = {1'b0, line_length} + (is_special ? (LINE_BITS+1)'(3) : (LINE_BITS+1)'(1));
  assign line_sat = (line_sum > {1'b0, LINE_SAT}) ? LINE_SAT : line_sum[LINE_BITS-1:0];

  always_comb begin
    total_count_next    = total_count;
    special_count_next  = special_count;
    ten_special_next    = ten_special;
    line_length_next    = line_length;
    long_line_seen_next = long_line_seen;
    nul_seen_next       = nul_seen;
    if (!nul_seen) begin
      if (!(&total_count)) begin
        total_count_next = total_count + COUNT_BITS'(1);
      end
      if (is_special && !(&special_count)) begin
        special_count_next = special_count + COUNT_BITS'(1);
        ten_special_next   = ten_special + TEN;
      end
      if (word.data_byte == BYTE_NUL) begin
        nul_seen_next = 1'b1;
      end
      if (word.data_byte == BYTE_LF) begin
        line_length_next = '0;
      end else begin
        line_length_next = line_sat;
        if (line_sat > LINE_MAX_LEN) begin
          long_line_seen_next = 1'b1;
        end
      end
    end
  end

  // special > total / 10 is the same as total < 10 * special
  always_comb begin
    result.binary_found = nul_seen_next;
    if (nul_seen_next) begin
      result.encoding_kind = ENC_BASE64;
    end else if (force_seven_bit || long_line_seen_next) begin
      result.encoding_kind = ({4'b0, total_count_next} < ten_special_next) ? ENC_BASE64 : ENC_QP;
    end else begin
      result.encoding_kind = (special_count_next != '0) ? ENC_8BIT : ENC_7BIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && word.last_byte)) begin
      total_count    <= '0;
      special_count  <= '0;
      ten_special    <= '0;
      line_length    <= '0;
      long_line_seen <= 1'b0;
      nul_seen       <= 1'b0;
    end else if (take) begin
      total_count    <= total_count_next;
      special_count  <= special_count_next;
      ten_special    <= ten_special_next;
      line_length    <= line_length_next;
      long_line_seen <= long_line_seen_next;
      nul_seen       <= nul_seen_next;
    end
  end

endmodule

// ----- rtl/mime_transfer_encoding_detect_core.sv -----
// Top level of the MIME content-transfer-encoding detector.
//
// Body bytes arrive on the byte channel (byte_valid, byte_stall, byte_word), one
// word per cycle while byte_stall is low; last_byte marks the final byte of a body. For each body one
// result word leaves on the result channel (result_valid, result_stall,
// result_word) carrying the chosen encoding and the NUL flag.
// A byte word lands in an input register, from which the counter update runs;
// on a last byte the decision is written to the result register.
// result_valid rises when that write is made, which waits while an earlier
// result is still stalled in the register.
// Throughput is one byte per cycle while byte_stall is low, set by the single counter update stage.
// While the result register is full and stalled, ordinary bytes still flow;
// only a last byte waits in the input register, which then stalls the input.
// force_seven_bit is set via cfg_write_en/cfg_write_data; users must write it only while idle (not enforced).
// Synchronous reset clears the counters, both valid flags and force_seven_bit.
module mime_transfer_encoding_detect_core import mted_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  output logic      byte_stall,
  input  in_word_t  byte_word,
  output logic      result_valid,
  input  logic      result_stall,
  output out_word_t result_word,
  input  logic      cfg_write_en,
  input  logic      cfg_write_data
);

  logic      hold_valid;
  in_word_t  hold_word;
  logic      advance;
  logic      force_seven_bit;
  out_word_t stats_result;

  assign advance    = hold_valid && (!hold_word.last_byte || !result_valid || !result_stall);
  assign byte_stall = hold_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      force_seven_bit <= 1'b0;
    end else if (cfg_write_en) begin
      force_seven_bit <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!byte_stall) begin
      hold_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      hold_word <= byte_word;
    end
  end

  mted_stats #(
    .COUNT_BITS(COUNT_BITS)
  ) u_stats (
    .clk(clk),
    .rst(rst),
    .take(advance),
    .word(hold_word),
    .force_seven_bit(force_seven_bit),
    .result(stats_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && hold_word.last_byte) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hold_word.last_byte) begin
      result_word <= stats_result;
    end
  end

  a_nul_gives_base64: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_word.binary_found |-> result_word.encoding_kind == ENC_BASE64)
    else $error("binary body not reported as base64");

  a_last_blocked: assert property (@(posedge clk) disable iff (rst)
    hold_valid && hold_word.last_byte && result_valid && result_stall |-> byte_stall)
    else $error("last byte taken while result register blocked");

  a_result_follows_last: assert property (@(posedge clk) disable iff (rst)
    advance && hold_word.last_byte |=> result_valid)
    else $error("result missing after last byte");

  a_plain_byte_flows: assert property (@(posedge clk) disable iff (rst)
    hold_valid && !hold_word.last_byte |-> !byte_stall)
    else $error("input stalled behind a non-final byte");

endmodule

// ----- test/mted_encoding_checker.sv -----
`timescale 1ns / 100ps
// Checker for the transfer-encoding detector: predicts each body's result word and compares.
module mted_encoding_checker import mted_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  input  logic      byte_stall,
  input  in_word_t  byte_word,
  input  logic      result_valid,
  input  logic      result_stall,
  input  out_word_t result_word,
  input  logic      cfg_write_en,
  input  logic      cfg_write_data,
  output int        fail_count,
  output int        words_due
);

  logic [COUNT_BITS-1:0] byte_total;
  logic [COUNT_BITS-1:0] special_total;
  logic [LINE_BITS-1:0]  line_len;
  logic                  long_line;
  logic                  nul_hit;
  logic                  seven_bit;
  out_word_t             expected_words[$];

  task automatic restart_body();
    byte_total = '0;
    special_total = '0;
    line_len = '0;
    long_line = 1'b0;
    nul_hit = 1'b0;
  endtask

  always @(posedge clk) begin : watch
    logic                 special;
    logic [LINE_BITS:0]   line_sum;
    logic [7:0]           b;
    out_word_t            want;
    if (rst) begin
      restart_body();
      seven_bit = 1'b0;
      fail_count = 0;
      expected_words.delete();
    end else begin
      if (cfg_write_en) begin
        seven_bit = cfg_write_data;
      end
      if (byte_valid && !byte_stall) begin
        b = byte_word.data_byte;
        // once a NUL is seen the rest of the body is ignored
        if (!nul_hit) begin
          special = (b < CTRL_LIMIT || b >= HIGH_BYTE) &&
                    b != BYTE_TAB && b != BYTE_CR && b != BYTE_LF;
          if (!(&byte_total)) begin
            byte_total = byte_total + 1'b1;
          end
          if (special && !(&special_total)) begin
            special_total = special_total + 1'b1;
          end
          line_sum = {1'b0, line_len} + (special ? 12'd3 : 12'd1);
          line_len = (line_sum > {1'b0, LINE_SAT}) ? LINE_SAT : line_sum[LINE_BITS-1:0];
          if (b == BYTE_NUL) begin
            nul_hit = 1'b1;
          end
          if (b == BYTE_LF) begin
            line_len = '0;
          end else if (line_len > LINE_MAX_LEN) begin
            long_line = 1'b1;
          end
        end
        if (byte_word.last_byte) begin
          want.binary_found = nul_hit;
          if (nul_hit) begin
            want.encoding_kind = ENC_BASE64;
          end else if (seven_bit || long_line) begin
            want.encoding_kind = (special_total > byte_total / 10) ? ENC_BASE64 : ENC_QP;
          end else begin
            want.encoding_kind = (special_total != 0) ? ENC_8BIT : ENC_7BIT;
          end
          expected_words.push_back(want);
          restart_body();
        end
      end
      if (result_valid && !result_stall) begin
        if (expected_words.size() == 0) begin
          $error("result word with no body pending: encoding_kind %0d binary_found %0b",
                 result_word.encoding_kind, result_word.binary_found);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          if (result_word.encoding_kind !== want.encoding_kind) begin
            $error("encoding_kind expected %0d got %0d",
                   want.encoding_kind, result_word.encoding_kind);
            fail_count++;
          end
          if (result_word.binary_found !== want.binary_found) begin
            $error("binary_found expected %0b got %0b",
                   want.binary_found, result_word.binary_found);
            fail_count++;
          end
        end
      end
    end
    words_due <= expected_words.size();
  end

endmodule

// ----- test/mime_transfer_encoding_detect_core_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the transfer-encoding detector: stimulus, receiver stalls and verdict.
module mime_transfer_encoding_detect_core_tb;
  import mted_pkg::*;

  localparam int COUNT_BITS     = 32;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int RANDOM_WORDS   = 430;
  localparam int CHUNKS         = 6;

  logic      clk;
  logic      rst;
  logic      byte_valid;
  logic      byte_stall;
  in_word_t  byte_word;
  logic      result_valid;
  logic      result_stall;
  out_word_t result_word;
  logic      cfg_write_en;
  logic      cfg_write_data;

  int fail_count;
  int words_due;
  int quiet_cycles;
  bit idle_on;
  bit hold_req;
  bit hold_served;

  mime_transfer_encoding_detect_core #(
    .COUNT_BITS(COUNT_BITS)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .byte_word     (byte_word),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result_word   (result_word),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data)
  );

  mted_encoding_checker #(
    .COUNT_BITS(COUNT_BITS)
  ) i_checker (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .byte_word     (byte_word),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result_word   (result_word),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .fail_count    (fail_count),
    .words_due     (words_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] pick_plain();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return BYTE_TAB;
      1: return BYTE_CR;
      2: return BYTE_LF;
      3: return 8'h7F;
      default: return 8'($urandom_range(8'h20, 8'h7E));
    endcase
  endfunction

  function automatic logic [7:0] pick_special();
    logic [7:0] b;
    if ($urandom_range(0, 3) == 0) begin
      b = 8'($urandom_range(1, 31));
      if (b == BYTE_TAB || b == BYTE_CR || b == BYTE_LF) begin
        b = 8'h1B;
      end
    end else begin
      b = 8'($urandom_range(8'h80, 8'hFF));
    end
    return b;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 16);
      byte_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_valid <= 1'b1;
    byte_word <= '{data_byte: b, last_byte: last};
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random_body(int len);
    int pct;
    logic [7:0] b;
    pct = $urandom_range(0, 4) * 10;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) == 0) begin
        b = BYTE_NUL;
      end else if ($urandom_range(0, 99) < pct) begin
        b = pick_special();
      end else begin
        b = pick_plain();
      end
      send_byte(b, i == len - 1);
    end
  endtask

  // sender pauses until every result word is back, then lets the pipe drain
  task automatic settle();
    byte_valid <= 1'b0;
    while (words_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_seven_bit(logic v);
    cfg_write_en <= 1'b1;
    cfg_write_data <= v;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int sent;
    int len;
    rst = 1'b1;
    byte_valid = 1'b0;
    byte_word = '0;
    cfg_write_en = 1'b0;
    cfg_write_data = 1'b0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    write_seven_bit(1'b0);

    send_byte(8'h41, 1'b1);
    send_byte(8'h80, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h7F, 1'b1);
    send_byte(BYTE_TAB, 1'b0);
    send_byte(BYTE_CR, 1'b0);
    send_byte(BYTE_LF, 1'b0);
    send_byte(8'h1F, 1'b1);
    // bytes after a NUL are not counted
    send_byte(BYTE_NUL, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h41, 1'b1);
    send_byte(BYTE_NUL, 1'b1);
    settle();

    // 7-bit safe: tenth-of-bytes threshold either side
    write_seven_bit(1'b1);
    for (int i = 0; i < 10; i++) begin
      send_byte((i == 0) ? 8'h80 : 8'(8'h61 + i), i == 9);
    end
    for (int i = 0; i < 5; i++) begin
      send_byte((i == 2) ? 8'h1F : 8'(8'h30 + i), i == 4);
    end
    settle();
    write_seven_bit(1'b0);

    // one line of specials, long enough to pass 990
    for (int i = 0; i < 340; i++) begin
      send_byte(pick_special(), i == 339);
    end
    settle();

    for (int chunk = 0; chunk < CHUNKS; chunk++) begin
      idle_on = (chunk != CHUNKS - 1);
      write_seven_bit(chunk[0]);
      if (chunk == 2) begin
        hold_req = 1'b1;
      end
      sent = 0;
      while (sent < RANDOM_WORDS / CHUNKS) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
        send_random_body(len);
        sent += len;
      end
      settle();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0 && words_due == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    int hold_left;
    int burst_left;
    hold_left = 0;
    burst_left = 0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        result_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(0, 15);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ----- sim.f -----
rtl/mted_pkg.sv
rtl/mted_stats.sv
rtl/mime_transfer_encoding_detect_core.sv
test/mted_encoding_checker.sv
test/mime_transfer_encoding_detect_core_tb.sv
